// ===== rtl/core/motor_feedback_multiturn_tracker_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_UNIT_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is asserted
`define MFMTU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also checks during reset
`define MFMTU_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/mfmt_pkg.sv =====
package mfmt_pkg;

  // Slot table size
  localparam int DEF_MOTOR_SLOTS = 6;
  localparam int IDX_W = 3;

  // Field widths
  localparam int ANGLE_W = 16;
  localparam int TURN_W  = 19;
  localparam int TOTAL_W = 32;
  localparam int JUMP_W  = ANGLE_W + 1;
  localparam int ERR_W   = TOTAL_W + 1;

  // Stream widths
  localparam int IN_DATA_W   = 64;
  localparam int IN_USER_W   = 12;
  localparam int OUT_FIELD_W = 3 * ANGLE_W + 8 + TURN_W + 2 * TOTAL_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = IDX_W + 1;

  // Frame identifiers
  localparam logic [10:0] ID_MOTOR_0 = 11'h201;
  localparam logic [10:0] ID_MOTOR_1 = 11'h202;
  localparam logic [10:0] ID_MOTOR_2 = 11'h203;
  localparam logic [10:0] ID_MOTOR_3 = 11'h204;
  localparam logic [10:0] ID_MOTOR_4 = 11'h207;
  localparam logic [10:0] ID_MOTOR_5 = 11'h205;

  localparam logic BUS_FIRST = 1'b0;

  // Slot codes
  localparam logic [IDX_W-1:0] SLOT_0 = 3'd0;
  localparam logic [IDX_W-1:0] SLOT_1 = 3'd1;
  localparam logic [IDX_W-1:0] SLOT_2 = 3'd2;
  localparam logic [IDX_W-1:0] SLOT_3 = 3'd3;
  localparam logic [IDX_W-1:0] SLOT_4 = 3'd4;
  localparam logic [IDX_W-1:0] SLOT_5 = 3'd5;
  localparam logic [IDX_W-1:0] REF_SLOT = SLOT_5;

  // Tracking constants
  localparam int JUMP_THRESHOLD = 4096;
  localparam int TICKS_PER_TURN = 8191;
  localparam int FOLD_SPAN      = 8190;
  localparam int TURN_LIMIT     = 262143;
  localparam int TICK_SHIFT     = $clog2(TICKS_PER_TURN + 1);

  localparam logic signed [JUMP_W-1:0]  JUMP_HI  = JUMP_W'(JUMP_THRESHOLD);
  localparam logic signed [JUMP_W-1:0]  JUMP_LO  = JUMP_W'(-JUMP_THRESHOLD);
  localparam logic signed [TURN_W-1:0]  TURN_MAX = TURN_W'(TURN_LIMIT);
  localparam logic signed [TURN_W-1:0]  TURN_MIN = TURN_W'(-TURN_LIMIT);
  localparam logic signed [TOTAL_W-1:0] TICKS    = TOTAL_W'(TICKS_PER_TURN);
  localparam logic signed [ERR_W-1:0]   FOLD_HI  = ERR_W'(FOLD_SPAN);
  localparam logic signed [ERR_W-1:0]   FOLD_LO  = ERR_W'(-FOLD_SPAN);

  // One slot of tracking state
  typedef struct packed {
    logic               seen;
    logic [ANGLE_W-1:0] start_ang;
    logic [ANGLE_W-1:0] last_ang;
    logic [TURN_W-1:0]  turns;
  } mfmt_entry_t;

  // Write request into the slot table
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
    mfmt_entry_t      data;
  } mfmt_wr_t;

  // Decoded frame, waiting on the table read
  typedef struct packed {
    logic               matched;
    logic [IDX_W-1:0]   slot;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        speed;
    logic [15:0]        torque;
    logic [7:0]         temp;
  } mfmt_s1_t;

  // Updated frame, waiting on the error fold
  typedef struct packed {
    logic               matched;
    logic [IDX_W-1:0]   slot;
    logic [ANGLE_W-1:0] angle;
    logic [15:0]        speed;
    logic [15:0]        torque;
    logic [7:0]         temp;
    logic [TURN_W-1:0]  turns;
    logic [TOTAL_W-1:0] total;
    logic [TOTAL_W-1:0] ref_total;
    logic [ANGLE_W-1:0] ref_start;
  } mfmt_s2_t;

endpackage

// ===== rtl/core/motor_feedback_multiturn_tracker_unit.sv =====
// Motor feedback multi-turn tracker. Each request is one received CAN frame
// (bus and identifier on in_tuser, eight data bytes on in_tdata); each gives
// exactly one result. The block sustains one frame per clock while the
// output is not stalled. The synchronous memory read of the per-slot state
// table is issued at the accepting edge, together with the decoded frame. The
// slot's read-modify-write follows in the update stage; a bypass register
// covers a frame to the same slot right behind. The position error fold
// comes after the update register and lands in the output register. A stalled
// output holds the pipeline back, and the ready path reaches in_tready in the
// same cycle. The table comes out of reset cleared through per-entry valid
// bits, so frames are taken from the first cycle after reset.
module motor_feedback_multiturn_tracker_unit #(
  parameter int MOTOR_SLOTS = mfmt_pkg::DEF_MOTOR_SLOTS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // byte_0 [7:0], byte_1, ..., byte_7 [63:56]
  input  logic [mfmt_pkg::IN_DATA_W-1:0]    in_tdata,
  // bus_select [0], frame_id [11:1]
  input  logic [mfmt_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // angle [15:0], speed [31:16], torque [47:32], temperature [55:48],
  // turn_count [74:56], unwrapped_angle [106:75], position_error [138:107], zero pad
  output logic [mfmt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // matched [0], motor_index [3:1]
  output logic [mfmt_pkg::OUT_USER_W-1:0]   out_tuser
);
  import mfmt_pkg::*;

  logic             rd_en;
  logic [IDX_W-1:0] rd_slot;
  logic             s1_valid;
  mfmt_s1_t         s1;
  mfmt_entry_t      rd_entry;
  mfmt_wr_t         wr;
  logic             upd_ready;
  logic             s2_valid;
  mfmt_s2_t         s2;
  logic             fold_ready;

  // Frame decode and table read issue
  mfmt_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_user  (in_tuser),
    .in_data  (in_tdata),
    .dn_ready (upd_ready),
    .in_ready (in_tready),
    .rd_en    (rd_en),
    .rd_slot  (rd_slot),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  // Per-slot tracking state
  mfmt_state_mem #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_state_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_slot  (rd_slot),
    .wr       (wr),
    .rd_entry (rd_entry)
  );

  // Turn tracking and write-back
  mfmt_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1       (s1),
    .entry    (rd_entry),
    .dn_ready (fold_ready),
    .up_ready (upd_ready),
    .wr       (wr),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  // Error fold and output register
  mfmt_fold u_fold (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_valid   (s2_valid),
    .s2         (s2),
    .out_tready (out_tready),
    .up_ready   (fold_ready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/core/mfmt_decode.sv =====
module mfmt_decode (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic [mfmt_pkg::IN_USER_W-1:0]    in_user,   // bus_select, frame_id
  input  logic [mfmt_pkg::IN_DATA_W-1:0]    in_data,   // byte_0 .. byte_7
  input  logic                              dn_ready,
  output logic                              in_ready,
  output logic                              rd_en,
  output logic [mfmt_pkg::IDX_W-1:0]        rd_slot,
  output logic                              s1_valid,
  output mfmt_pkg::mfmt_s1_t                s1
);
  import mfmt_pkg::*;

  logic        bus;
  logic [10:0] id;
  logic        hit;
  logic [IDX_W-1:0] slot;
  mfmt_s1_t    s1_nxt;
  mfmt_s1_t    s1_r;
  logic        s1_valid_r;

  assign bus = in_user[0];
  assign id  = in_user[11:1];

  // Slot lookup from bus and identifier
  always_comb begin
    hit  = 1'b0;
    slot = SLOT_0;
    if (bus == BUS_FIRST) begin
      case (id)
        ID_MOTOR_0: begin hit = 1'b1; slot = SLOT_0; end
        ID_MOTOR_1: begin hit = 1'b1; slot = SLOT_1; end
        ID_MOTOR_2: begin hit = 1'b1; slot = SLOT_2; end
        ID_MOTOR_3: begin hit = 1'b1; slot = SLOT_3; end
        ID_MOTOR_4: begin hit = 1'b1; slot = SLOT_4; end
        default: begin hit = 1'b0; slot = SLOT_0; end
      endcase
    end else if (id == ID_MOTOR_5) begin
      hit  = 1'b1;
      slot = SLOT_5;
    end
  end

  // Big-endian unpack
  always_comb begin
    s1_nxt.matched = hit;
    s1_nxt.slot    = slot;
    s1_nxt.angle   = {in_data[7:0], in_data[15:8]};
    s1_nxt.speed   = {in_data[23:16], in_data[31:24]};
    s1_nxt.torque  = {in_data[39:32], in_data[47:40]};
    s1_nxt.temp    = in_data[55:48];
  end

  // Stage moves whenever it is empty or drains downstream
  assign in_ready = !s1_valid_r || dn_ready;
  assign rd_en    = in_ready;
  assign rd_slot  = slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

// ===== rtl/core/mfmt_state_mem.sv =====
module mfmt_state_mem #(
  parameter int MOTOR_SLOTS = mfmt_pkg::DEF_MOTOR_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  logic [mfmt_pkg::IDX_W-1:0]  rd_slot,
  input  mfmt_pkg::mfmt_wr_t          wr,
  output mfmt_pkg::mfmt_entry_t       rd_entry
);
  import mfmt_pkg::*;

  localparam int SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

  mfmt_entry_t             mem_r [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0]  valid_r;
  mfmt_entry_t             rd_data_r;
  mfmt_entry_t             fwd_data_r;
  logic                    rd_ok_r;
  logic                    fwd_hit_r;
  logic [SLOT_W-1:0]       rd_addr;
  logic [SLOT_W-1:0]       wr_addr;

  assign rd_addr = SLOT_W'(rd_slot);
  assign wr_addr = SLOT_W'(wr.slot);

  // Table array, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr_addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      fwd_data_r <= wr.data;
    end
  end

  // Per-entry valid bits stand in for the zero reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_ok_r   <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r   <= valid_r[rd_addr];
        fwd_hit_r <= wr.en && (wr_addr == rd_addr);
      end
    end
  end

  // Write in the read cycle to the same slot wins over the array
  assign rd_entry = fwd_hit_r ? fwd_data_r : (rd_ok_r ? rd_data_r : '0);

endmodule

// ===== rtl/core/mfmt_update.sv =====
module mfmt_update (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  mfmt_pkg::mfmt_s1_t     s1,
  input  mfmt_pkg::mfmt_entry_t  entry,
  input  logic                   dn_ready,
  output logic                   up_ready,
  output mfmt_pkg::mfmt_wr_t     wr,
  output logic                   s2_valid,
  output mfmt_pkg::mfmt_s2_t     s2
);
  import mfmt_pkg::*;

  logic [ANGLE_W-1:0]        ang;
  logic [ANGLE_W-1:0]        last_eff;
  logic [ANGLE_W-1:0]        last_out;
  logic [ANGLE_W-1:0]        start_out;
  logic                      hit;
  logic                      ref_hit;
  logic                      go_dn;
  logic                      go_up;
  logic                      fire;
  logic signed [JUMP_W-1:0]  jump;
  logic signed [TURN_W-1:0]  t_cur;
  logic signed [TURN_W-1:0]  t_new;
  logic signed [TOTAL_W-1:0] t_wide;
  logic signed [TOTAL_W-1:0] base;
  logic signed [TOTAL_W-1:0] tot_dn;
  logic signed [TOTAL_W-1:0] tot_up;
  logic signed [TOTAL_W-1:0] total;
  mfmt_entry_t               entry_nxt;
  mfmt_s2_t                  s2_nxt;
  mfmt_s2_t                  s2_r;
  logic                      s2_valid_r;
  logic [TOTAL_W-1:0]        ref_total_r;
  logic [ANGLE_W-1:0]        ref_start_r;

  // Jump test against the previous angle (first sample compares to itself)
  always_comb begin
    ang      = s1.angle;
    hit      = s1.matched && (ang != '0);
    last_eff = entry.seen ? entry.last_ang : ang;
    jump     = $signed({1'b0, ang}) - $signed({1'b0, last_eff});
    t_cur    = $signed(entry.turns);
    go_dn    = hit && (jump > JUMP_HI) && (t_cur > TURN_MIN);
    go_up    = hit && (jump < JUMP_LO) && (t_cur < TURN_MAX);
    if (go_dn) begin
      t_new = t_cur - TURN_W'(1);
    end else if (go_up) begin
      t_new = t_cur + TURN_W'(1);
    end else begin
      t_new = t_cur;
    end
  end

  // Total from old turns, with the one-turn step chosen afterward
  always_comb begin
    last_out  = hit ? ang : entry.last_ang;
    start_out = (hit && !entry.seen) ? ang : entry.start_ang;
    t_wide    = {{(TOTAL_W - TURN_W){t_cur[TURN_W-1]}}, t_cur};
    base      = (t_wide <<< TICK_SHIFT) - t_wide
              + $signed({{(TOTAL_W - ANGLE_W){1'b0}}, last_out});
    tot_dn    = base - TICKS;
    tot_up    = base + TICKS;
    if (go_dn) begin
      total = tot_dn;
    end else if (go_up) begin
      total = tot_up;
    end else begin
      total = base;
    end
  end

  always_comb begin
    entry_nxt.seen      = entry.seen || hit;
    entry_nxt.start_ang = start_out;
    entry_nxt.last_ang  = last_out;
    entry_nxt.turns     = t_new;
  end

  assign up_ready = !s2_valid_r || dn_ready;
  assign fire     = s1_valid && up_ready;
  assign ref_hit  = hit && (s1.slot == REF_SLOT);

  // Write back only on a tracked sample
  assign wr.en   = fire && hit;
  assign wr.slot = s1.slot;
  assign wr.data = entry_nxt;

  always_comb begin
    s2_nxt.matched   = s1.matched;
    s2_nxt.slot      = s1.slot;
    s2_nxt.angle     = s1.angle;
    s2_nxt.speed     = s1.speed;
    s2_nxt.torque    = s1.torque;
    s2_nxt.temp      = s1.temp;
    s2_nxt.turns     = t_new;
    s2_nxt.total     = total;
    s2_nxt.ref_total = ref_hit ? total : ref_total_r;
    s2_nxt.ref_start = ref_hit ? start_out : ref_start_r;
  end

  // Reference slot total and start, kept for the error output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_total_r <= '0;
      ref_start_r <= '0;
    end else if (fire && ref_hit) begin
      ref_total_r <= total;
      ref_start_r <= start_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (up_ready) begin
      s2_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

// ===== rtl/core/mfmt_fold.sv =====
module mfmt_fold (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s2_valid,
  input  mfmt_pkg::mfmt_s2_t                s2,
  input  logic                              out_tready,
  output logic                              up_ready,
  output logic                              out_tvalid,
  output logic [mfmt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [mfmt_pkg::OUT_USER_W-1:0]   out_tuser
);
  import mfmt_pkg::*;

  logic signed [ERR_W-1:0]  diff;
  logic signed [ERR_W-1:0]  err_dn;
  logic signed [ERR_W-1:0]  err_up;
  logic signed [ERR_W-1:0]  err;
  logic [OUT_DATA_W-1:0]    data_nxt;
  logic [OUT_USER_W-1:0]    user_nxt;
  logic [OUT_DATA_W-1:0]    data_r;
  logic [OUT_USER_W-1:0]    user_r;
  logic                     out_valid_r;

  // Fold the reference error once by the span, candidates in parallel
  always_comb begin
    diff   = $signed({s2.ref_total[TOTAL_W-1], s2.ref_total})
           - $signed({{(ERR_W - ANGLE_W){1'b0}}, s2.ref_start});
    err_dn = diff - FOLD_HI;
    err_up = diff + FOLD_HI;
    if (diff > FOLD_HI) begin
      err = err_dn;
    end else if (diff < FOLD_LO) begin
      err = err_up;
    end else begin
      err = diff;
    end
  end

  // Pack result; unmatched frames report all zeros
  always_comb begin
    if (s2.matched) begin
      data_nxt = {{(OUT_DATA_W - OUT_FIELD_W){1'b0}}, err[TOTAL_W-1:0], s2.total,
                  s2.turns, s2.temp, s2.torque, s2.speed, s2.angle};
      user_nxt = {s2.slot, 1'b1};
    end else begin
      data_nxt = '0;
      user_nxt = '0;
    end
  end

  assign up_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

endmodule

// ===== rtl/core/mfmt_checker.sv =====
`include "motor_feedback_multiturn_tracker_unit_assert.svh"

module mfmt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [mfmt_pkg::IN_DATA_W-1:0]    in_tdata,
  input logic [mfmt_pkg::IN_USER_W-1:0]    in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mfmt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [mfmt_pkg::OUT_USER_W-1:0]   out_tuser
);

  // Stalled result holds
  `MFMTU_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Unmatched frame reports all zeros
  `MFMTU_ASSERT(a_unmatched_zero, clk, rst_n, out_tvalid && !out_tuser[0] |-> out_tdata == '0 && out_tuser == '0)

  // Slot index stays within the six motor slots
  `MFMTU_ASSERT(a_slot_range, clk, rst_n, out_tvalid && out_tuser[0] |-> out_tuser[3:1] != 3'd6 && out_tuser[3:1] != 3'd7)

  // Turn count never reaches the most negative code
  `MFMTU_ASSERT(a_turn_sat, clk, rst_n, out_tvalid |-> out_tdata[74:56] != 19'h40000)

  // Reset empties the pipeline and opens the input
  `MFMTU_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind motor_feedback_multiturn_tracker_unit mfmt_checker u_mfmt_checker (.*);
